[hdl/htfd_pkg.sv]
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the crc-8 byte update for the humidity and
// temperature frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

    // crc-8, polynomial x^8 + x^5 + x^4 + 1, preset all ones
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // frame byte positions; idle sits past the last byte
    localparam int FRAME_BYTES = 6;
    localparam logic [2:0] IDLE_INDEX = 3'(FRAME_BYTES);

    // conversion constants
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] HUMI_SCALE  = 15'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    // job queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // one checked word handed from front to back; status bits already dropped
    typedef struct packed {
        logic        is_humi;
        logic        crc_ok;
        logic [13:0] raw;
    } job_t;

    // one byte of crc-8, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hdl/htfd_front.sv]
// ----------------------------------------------------------------------------
// htfd_front
// Tracks the byte position in the frame, runs the crc over each word and
// pushes one checked word job per crc byte.
// ----------------------------------------------------------------------------
module htfd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  logic              frame_start,
    input  logic              queue_full,
    output logic              push_valid,
    output htfd_pkg::job_t    push_job
);
    import htfd_pkg::*;

    localparam logic [2:0] BYTE_T_HI  = 3'd0;
    localparam logic [2:0] BYTE_T_LO  = 3'd1;
    localparam logic [2:0] BYTE_T_CRC = 3'd2;
    localparam logic [2:0] BYTE_H_HI  = 3'd3;
    localparam logic [2:0] BYTE_H_LO  = 3'd4;
    localparam logic [2:0] BYTE_H_CRC = 3'd5;

    logic [2:0] byte_index_reg, byte_index_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] high_reg, high_next;
    logic [7:0] low_reg, low_next;
    logic [2:0] idx;
    logic       beat;

    assign in_ready = ~queue_full;
    assign beat     = in_valid & in_ready;
    assign idx      = frame_start ? BYTE_T_HI : byte_index_reg;

    // byte classification and crc update
    always_comb
    begin
        byte_index_next = byte_index_reg;
        crc_next        = crc_reg;
        high_next       = high_reg;
        low_next        = low_reg;
        push_valid      = 1'b0;
        push_job        = '{is_humi: 1'b0, crc_ok: 1'b0, raw: {high_reg, low_reg[7:2]}};
        if (beat)
        begin
            case (idx)
                BYTE_T_HI, BYTE_H_HI:
                begin
                    high_next       = rx_byte;
                    crc_next        = crc8_byte(CRC_INIT, rx_byte);
                    byte_index_next = idx + 3'd1;
                end
                BYTE_T_LO, BYTE_H_LO:
                begin
                    low_next        = rx_byte;
                    crc_next        = crc8_byte(crc_reg, rx_byte);
                    byte_index_next = idx + 3'd1;
                end
                BYTE_T_CRC:
                begin
                    push_valid      = 1'b1;
                    push_job.crc_ok = (crc_reg == rx_byte);
                    crc_next        = CRC_INIT;
                    byte_index_next = BYTE_H_HI;
                end
                BYTE_H_CRC:
                begin
                    push_valid       = 1'b1;
                    push_job.is_humi = 1'b1;
                    push_job.crc_ok  = (crc_reg == rx_byte);
                    crc_next         = CRC_INIT;
                    byte_index_next  = IDLE_INDEX;
                end
                default:
                begin
                    // idle: byte dropped
                    byte_index_next = byte_index_reg;
                end
            endcase
        end
    end

    // frame position and word capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= IDLE_INDEX;
            crc_reg        <= CRC_INIT;
            high_reg       <= '0;
            low_reg        <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
            high_reg       <= high_next;
            low_reg        <= low_next;
        end
    end

endmodule

[hdl/htfd_queue.sv]
// ----------------------------------------------------------------------------
// htfd_queue
// Small first-in first-out queue of word jobs between front and back.
// ----------------------------------------------------------------------------
module htfd_queue
#(
    parameter int DEPTH = htfd_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  htfd_pkg::job_t    push_job,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output htfd_pkg::job_t    pop_job
);
    import htfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid & ~full;
    assign do_pop    = pop & pop_valid;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

[hdl/htfd_back.sv]
// ----------------------------------------------------------------------------
// htfd_back
// Scales each good word to fixed point, keeps the last good values and
// drives the result register after the humidity word.
// ----------------------------------------------------------------------------
module htfd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  htfd_pkg::job_t      job,
    output logic                job_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [14:0]  temperature_centi,
    output logic [13:0]         humidity_centi,
    output logic                temp_crc_ok,
    output logic                humi_crc_ok
);
    import htfd_pkg::*;

    logic               s1_valid_reg;
    logic               s1_humi_reg;
    logic               s1_ok_reg;
    logic [30:0]        s1_prod_reg;
    logic [30:0]        prod_next;
    logic               s1_load, s2_go;

    logic signed [14:0] held_temp_reg;
    logic [13:0]        held_humi_reg;
    logic               temp_ok_reg;

    logic               out_valid_reg;
    logic signed [14:0] out_temp_reg;
    logic [13:0]        out_humi_reg;
    logic               out_tok_reg;
    logic               out_hok_reg;

    logic [14:0]        q_hi;
    logic [16:0]        rem;
    logic [14:0]        quot;
    logic [14:0]        temp_val;

    // stage 2 may retire unless a humidity word finds the result register held
    assign s2_go   = s1_valid_reg & (~s1_humi_reg | ~out_valid_reg | out_ready);
    assign s1_load = ~s1_valid_reg | s2_go;
    assign job_pop = s1_load & job_valid;

    // stage 1: scale multiply
    assign prod_next = 31'({job.raw, 2'b00})
                     * 31'(job.is_humi ? HUMI_SCALE : TEMP_SCALE);

    // stage 2: divide by 65535 as shift plus one correction, then offset
    assign q_hi     = s1_prod_reg[30:16];
    assign rem      = {1'b0, s1_prod_reg[15:0]} + {2'b00, q_hi};
    assign quot     = q_hi + ((rem >= FULL_SCALE) ? 15'd1 : 15'd0);
    assign temp_val = quot - TEMP_OFFSET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_humi_reg   <= 1'b0;
            s1_ok_reg     <= 1'b0;
            s1_prod_reg   <= '0;
            held_temp_reg <= '0;
            held_humi_reg <= '0;
            temp_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_temp_reg  <= '0;
            out_humi_reg  <= '0;
            out_tok_reg   <= 1'b0;
            out_hok_reg   <= 1'b0;
        end
        else
        begin
            // stage 1 register
            if (s1_load)
            begin
                s1_valid_reg <= job_valid;
                s1_humi_reg  <= job.is_humi;
                s1_ok_reg    <= job.crc_ok;
                s1_prod_reg  <= prod_next;
            end

            // result valid: set by a humidity word, else cleared once taken
            if (s2_go && s1_humi_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // stage 2: update held values, emit after humidity word
            if (s2_go)
            begin
                if (!s1_humi_reg)
                begin
                    temp_ok_reg <= s1_ok_reg;
                    if (s1_ok_reg)
                    begin
                        held_temp_reg <= $signed(temp_val);
                    end
                end
                else
                begin
                    if (s1_ok_reg)
                    begin
                        held_humi_reg <= quot[13:0];
                    end
                    out_temp_reg  <= held_temp_reg;
                    out_humi_reg  <= s1_ok_reg ? quot[13:0] : held_humi_reg;
                    out_tok_reg   <= temp_ok_reg;
                    out_hok_reg   <= s1_ok_reg;
                end
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign temperature_centi = out_temp_reg;
    assign humidity_centi    = out_humi_reg;
    assign temp_crc_ok       = out_tok_reg;
    assign humi_crc_ok       = out_hok_reg;

endmodule

[hdl/humidity_temp_frame_decoder.sv]
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes six-byte humidity and temperature sensor frames into fixed point.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle (temperature high, low, crc, then humidity
// high, low, crc; frame_start marks the first byte) and returns one result
// per complete frame carrying the last good temperature in hundredths of a
// degree, the last good humidity in hundredths of a percent and both crc
// flags. The front checks the crc-8 as bytes arrive and hands each checked
// word to a job queue of QUEUE_DEPTH entries; the back scales it through a
// multiply stage and a divide-and-offset stage. A byte is accepted every
// cycle while the job queue has room; a result passes the job queue, stage 1
// and the result register, and a stalled result register holds back only
// the back half, so in_ready drops only once the job queue has filled.
module humidity_temp_frame_decoder
#(
    parameter int QUEUE_DEPTH = htfd_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [14:0]  temperature_centi,
    output logic [13:0]         humidity_centi,
    output logic                temp_crc_ok,
    output logic                humi_crc_ok
);
    import htfd_pkg::*;

    logic queue_full;
    logic push_valid;
    job_t push_job;
    logic pop;
    logic pop_valid;
    job_t pop_job;

    // byte tracking and crc check
    htfd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .queue_full  (queue_full),
        .push_valid  (push_valid),
        .push_job    (push_job)
    );

    // word job queue
    htfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job)
    );

    // conversion and result register
    htfd_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .job_valid         (pop_valid),
        .job               (pop_job),
        .job_pop           (pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .temp_crc_ok       (temp_crc_ok),
        .humi_crc_ok       (humi_crc_ok)
    );

endmodule

[tb/htfd_reading_checker.sv]
// ----------------------------------------------------------------------------
// htfd_reading_checker
// Watches both channels of the frame decoder, predicts each reading and
// compares it with what the block returns.
// ----------------------------------------------------------------------------
// Every accepted input beat is run through a cycle-free copy of the decoder
// (byte position, crc-8, held temperature and humidity). A completed frame
// queues one expected reading; every accepted result is compared field by
// field with the oldest queued reading. The failure count and the number of
// readings still due are handed to the testbench top.
module htfd_reading_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [14:0] temperature_centi,
    input  logic [13:0]        humidity_centi,
    input  logic               temp_crc_ok,
    input  logic               humi_crc_ok,
    output int                 fail_count,
    output int                 readings_due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0]  POLY        = 8'h31;
    localparam logic [7:0]  SEED        = 8'hFF;
    localparam logic [2:0]  POS_IDLE    = 3'd6;
    localparam logic [2:0]  POS_T_CRC   = 3'd2;
    localparam logic [2:0]  POS_H_CRC   = 3'd5;
    localparam logic [15:0] STATUS_BITS = 16'h0003;

    typedef struct packed {
        logic [14:0] temp;
        logic [13:0] humi;
        logic        temp_ok;
        logic        humi_ok;
    } reading_t;

    // decoder state as seen from outside
    logic [2:0]  frame_pos;
    logic [7:0]  crc_acc;
    logic [7:0]  hi_byte;
    logic [7:0]  lo_byte;
    logic [14:0] last_temp;
    logic [13:0] last_humi;
    logic        temp_good;

    reading_t readings_due[$];

    // crc-8 over one byte, msb first
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // sensor word with the status bits cleared
    function automatic logic [15:0] sensor_raw();
        return {hi_byte, lo_byte} & ~STATUS_BITS;
    endfunction

    // advance the decoder by one accepted beat
    task automatic take_byte(input logic [7:0] b, input logic s);
        reading_t        r;
        longint unsigned scaled;
        logic            ok;
        if (s)
        begin
            frame_pos = 3'd0;
        end
        if (frame_pos != POS_IDLE)
        begin
            case (frame_pos)
                3'd0, 3'd3:
                begin
                    hi_byte = b;
                    crc_acc = crc_update(SEED, b);
                end
                3'd1, 3'd4:
                begin
                    lo_byte = b;
                    crc_acc = crc_update(crc_acc, b);
                end
                POS_T_CRC:
                begin
                    ok = (crc_acc == b);
                    temp_good = ok;
                    if (ok)
                    begin
                        scaled = (17500 * sensor_raw()) / 65535;
                        last_temp = 15'(scaled - 4500);
                    end
                    crc_acc = SEED;
                end
                default:
                begin
                    ok = (crc_acc == b);
                    if (ok)
                    begin
                        scaled = (10000 * sensor_raw()) / 65535;
                        last_humi = 14'(scaled);
                    end
                    crc_acc = SEED;
                    r.temp = last_temp;
                    r.humi = last_humi;
                    r.temp_ok = temp_good;
                    r.humi_ok = ok;
                    readings_due.push_back(r);
                end
            endcase
            frame_pos = (frame_pos == POS_H_CRC) ? POS_IDLE : frame_pos + 3'd1;
        end
    endtask

    // results are checked before the input beat of the same edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t due;
        logic     field_bad;
        if (!rst_n)
        begin
            frame_pos = POS_IDLE;
            crc_acc = SEED;
            hi_byte = 8'h00;
            lo_byte = 8'h00;
            last_temp = 15'd0;
            last_humi = 14'd0;
            temp_good = 1'b0;
            readings_due.delete();
            readings_due_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (readings_due.size() == 0)
                begin
                    $display("%0t: reading with none due: temperature_centi %0d humidity_centi %0d",
                             $time, temperature_centi, humidity_centi);
                    fail_count++;
                end
                else
                begin
                    due = readings_due.pop_front();
                    field_bad = 1'b0;
                    if (temperature_centi !== due.temp)
                    begin
                        $display("%0t: temperature_centi expected %0d got %0d",
                                 $time, $signed(due.temp), temperature_centi);
                        field_bad = 1'b1;
                    end
                    if (humidity_centi !== due.humi)
                    begin
                        $display("%0t: humidity_centi expected %0d got %0d",
                                 $time, due.humi, humidity_centi);
                        field_bad = 1'b1;
                    end
                    if (temp_crc_ok !== due.temp_ok)
                    begin
                        $display("%0t: temp_crc_ok expected %0b got %0b",
                                 $time, due.temp_ok, temp_crc_ok);
                        field_bad = 1'b1;
                    end
                    if (humi_crc_ok !== due.humi_ok)
                    begin
                        $display("%0t: humi_crc_ok expected %0b got %0b",
                                 $time, due.humi_ok, humi_crc_ok);
                        field_bad = 1'b1;
                    end
                    if (field_bad)
                    begin
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                take_byte(rx_byte, frame_start);
            end
            readings_due_count = readings_due.size();
        end
    end

endmodule

[tb/humidity_temp_frame_decoder_test.sv]
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_test
// Stimulus and verdict for the humidity and temperature frame decoder.
// ----------------------------------------------------------------------------
// Sends a short directed set of frames (idle beats, failed crcs before any
// good word, a restart mid-frame, full-scale and zero words) and then random
// frames, truncated frames and stray beats. Both sides idle at random; once
// the result side holds off long enough to back up the input, and the input
// side pauses until every reading has come back. Checking is done by
// htfd_reading_checker.
module humidity_temp_frame_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS   = 500;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_CHOICES [3] = '{0, 4, 15};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte = 8'h00;
    logic               frame_start = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               temp_crc_ok;
    logic               humi_crc_ok;

    int fail_count;
    int readings_due_count;
    int send_idle_max = 3;
    int recv_idle_max = 3;
    int hold_off_asked = 0;
    int beats_counted = 0;
    int quiet_cycles = 0;

    humidity_temp_frame_decoder dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rx_byte           (rx_byte),
        .frame_start       (frame_start),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .temp_crc_ok       (temp_crc_ok),
        .humi_crc_ok       (humi_crc_ok)
    );

    htfd_reading_checker chk
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .rx_byte            (rx_byte),
        .frame_start        (frame_start),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .temperature_centi  (temperature_centi),
        .humidity_centi     (humidity_centi),
        .temp_crc_ok        (temp_crc_ok),
        .humi_crc_ok        (humi_crc_ok),
        .fail_count         (fail_count),
        .readings_due_count (readings_due_count)
    );

    always #5 clk = ~clk;

    // crc-8 of a whole sensor word, bit serial
    function automatic logic [7:0] word_check(input logic [15:0] w);
        logic [7:0] c;
        logic       fb;
        c = 8'hFF;
        for (int i = 15; i >= 0; i--)
        begin
            fb = c[7] ^ w[i];
            c = {c[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
        end
        return c;
    endfunction

    // words biased towards the ends of the scale
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0003;
            3: return 16'hFFFC;
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one beat after a random gap and wait for it to be taken
    task automatic put_beat(input logic [7:0] b, input logic s);
        int gap;
        gap = $urandom_range(0, send_idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        frame_start <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // first len beats of a frame; a bad crc is the good one with bits flipped
    task automatic send_frame(input logic [15:0] t_word, input logic t_good,
                              input logic [15:0] h_word, input logic h_good,
                              input int len);
        logic [7:0] fb [6];
        fb[0] = t_word[15:8];
        fb[1] = t_word[7:0];
        fb[2] = word_check(t_word) ^ (t_good ? 8'h00 : 8'($urandom_range(1, 255)));
        fb[3] = h_word[15:8];
        fb[4] = h_word[7:0];
        fb[5] = word_check(h_word) ^ (h_good ? 8'h00 : 8'($urandom_range(1, 255)));
        for (int i = 0; i < len; i++)
        begin
            put_beat(fb[i], i == 0);
        end
        beats_counted += len;
    endtask

    // stop sending until every reading has come back
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        do @(posedge clk); while (readings_due_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random stalls, one long hold-off when asked
    initial
    begin : result_taker
        int pause;
        int holds_served;
        holds_served = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            pause = $urandom_range(0, recv_idle_max);
            if (hold_off_asked != holds_served)
            begin
                pause = HOLD_CYCLES;
                holds_served = hold_off_asked;
            end
            if (pause > 0)
            begin
                out_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int frames;
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stray beat while idle
        put_beat(8'hA5, 1'b0);
        // both crcs failing before any good word
        send_frame(16'h0000, 1'b0, 16'h0000, 1'b0, 6);
        // partial frame dropped by a restart
        send_frame(16'h8001, 1'b1, 16'h4000, 1'b1, 2);
        // full scale temperature, zero humidity
        send_frame(16'hFFFF, 1'b1, 16'h0000, 1'b1, 6);
        // zero temperature, full scale humidity
        send_frame(16'h0000, 1'b1, 16'hFFFF, 1'b1, 6);
        // stray beat after a complete frame
        put_beat(8'h5A, 1'b0);
        wait_for_quiet();

        // random frames, truncated frames and stray beats
        beats_counted = 0;
        frames = 0;
        while (beats_counted < RANDOM_BEATS)
        begin
            frames++;
            if (frames % 25 == 0)
            begin
                send_idle_max = IDLE_CHOICES[$urandom_range(0, 2)];
                recv_idle_max = IDLE_CHOICES[$urandom_range(0, 2)];
            end
            if (frames == 30)
            begin
                hold_off_asked++;
                send_idle_max = 0;
            end
            if (frames == 60)
            begin
                wait_for_quiet();
            end
            case ($urandom_range(0, 9))
                0:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) put_beat(8'($urandom), 1'b0);
                end
                1:
                begin
                    send_frame(pick_word(), $urandom_range(0, 3) != 0,
                               pick_word(), $urandom_range(0, 3) != 0,
                               $urandom_range(1, 5));
                end
                default:
                begin
                    send_frame(pick_word(), $urandom_range(0, 3) != 0,
                               pick_word(), $urandom_range(0, 3) != 0, 6);
                end
            endcase
        end
        wait_for_quiet();

        if (fail_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
